>>> rtl/rpws_pkg.sv
// Shared types and constants for the row projection word segmenter.
`default_nettype none

package rpws_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int OUT_DEPTH   = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [1:0] {
        ST_BOX  = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_LEFT   = 3'd0,
        CFG_AREA_TOP    = 3'd1,
        CFG_AREA_RIGHT  = 3'd2,
        CFG_AREA_BOTTOM = 3'd3,
        CFG_DARK_THRESH = 3'd4,
        CFG_AREA_PAD    = 3'd5,
        CFG_WORD_MARGIN = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic        is_dark;
        logic        frame_end;
    } t_pixel;

    typedef struct packed {
        t_status     status;
        logic [11:0] box_left;
        logic [11:0] box_right;
        logic [11:0] box_top;
        logic [11:0] box_bottom;
        logic [11:0] word_index;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/row_projection_word_segmenter_unit.sv
// Top level of the row projection word segmenter.
`default_nettype none

// Takes raster pixels one per clock and counts dark pixels per row inside the
// search area shrunk by the padding; runs of rows above the threshold become
// word boxes spanning the padded width, with the margin added above and below. A pixel is
// judged while it sits in the input register, and its results (a box, and on
// frame end a done or error result) enter a four-entry result queue when it
// leaves that register. Throughput is one pixel per clock while the output
// side keeps up; input stalls only when the queue lacks room for two results.
// Between input and output lie the input register and the result queue.
// Configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// and must only change while the block is idle.

module row_projection_word_segmenter_unit
    import rpws_pkg::*;
#(
    parameter int P_MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_pixel                i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_result                    o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LIM_INT = (P_MAX_DIM - 1 > 4095) ? 4095 : P_MAX_DIM - 1;
    localparam logic signed [13:0] LIM = 14'(LIM_INT);
    localparam logic [12:0] COUNT_MAX = '1;

    // configuration
    logic [11:0] r_area_left, r_area_top, r_area_right, r_area_bottom;
    logic [12:0] r_dark_thresh;
    logic [10:0] r_area_pad;
    logic [7:0]  r_word_margin;

    // input register
    logic        r_in_valid;
    t_pixel      r_in;

    // frame state
    logic [12:0] r_cnt;
    logic        r_band;
    logic [11:0] r_start;
    logic [11:0] r_wcnt;

    logic signed [13:0] pl, pt, pr, pb, x, y;
    logic signed [13:0] first_row, last_row, top_raw, bot_raw, top_c, bot_c;
    logic        empty, in_area, at_edge, ink, band_after, close_gap, close_bot;
    logic        box_v, fire, room2;
    logic [12:0] cnt_inc;
    logic [11:0] start_after, wcnt_after;
    t_result     box_res, done_res, d0, d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_left   <= '0;
            r_area_top    <= '0;
            r_area_right  <= 12'hFFF;
            r_area_bottom <= 12'hFFF;
            r_dark_thresh <= '0;
            r_area_pad    <= '0;
            r_word_margin <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AREA_LEFT:   r_area_left   <= i_cfg_data[11:0];
                CFG_AREA_TOP:    r_area_top    <= i_cfg_data[11:0];
                CFG_AREA_RIGHT:  r_area_right  <= i_cfg_data[11:0];
                CFG_AREA_BOTTOM: r_area_bottom <= i_cfg_data[11:0];
                CFG_DARK_THRESH: r_dark_thresh <= i_cfg_data;
                CFG_AREA_PAD:    r_area_pad    <= i_cfg_data[10:0];
                CFG_WORD_MARGIN: r_word_margin <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign fire       = r_in_valid && room2;
    assign o_in_ready = !r_in_valid || room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // padded area bounds, signed so that an empty area shows as pl > pr or pt > pb
    always_comb begin
        pl = $signed({2'b00, r_area_left})   + $signed({3'b000, r_area_pad});
        pt = $signed({2'b00, r_area_top})    + $signed({3'b000, r_area_pad});
        pr = $signed({2'b00, r_area_right})  - $signed({3'b000, r_area_pad});
        pb = $signed({2'b00, r_area_bottom}) - $signed({3'b000, r_area_pad});
        x  = $signed({2'b00, r_in.pixel_x});
        y  = $signed({2'b00, r_in.pixel_y});
        empty   = (pl > pr) || (pt > pb);
        in_area = !empty && (x >= pl) && (x <= pr) && (y >= pt) && (y <= pb);
        at_edge = in_area && (x == pr);
    end

    // row judgment
    always_comb begin
        cnt_inc     = (r_in.is_dark && r_cnt != COUNT_MAX) ? r_cnt + 13'd1 : r_cnt;
        ink         = cnt_inc > r_dark_thresh;
        close_gap   = at_edge && !ink && r_band;
        band_after  = at_edge ? ink : r_band;
        start_after = (at_edge && ink && !r_band) ? r_in.pixel_y : r_start;
        close_bot   = at_edge && band_after && (y == pb);
        box_v       = close_gap || close_bot;
        wcnt_after  = r_wcnt + 12'(box_v);
    end

    // box rows with margin, clamped into 0 .. limit
    always_comb begin
        first_row = $signed({2'b00, start_after});
        last_row  = close_gap ? y - 14'sd1 : pb;
        top_raw   = first_row - $signed({6'b0, r_word_margin});
        bot_raw   = last_row + $signed({6'b0, r_word_margin});
        top_c     = (top_raw < 0) ? '0 : ((top_raw > LIM) ? LIM : top_raw);
        bot_c     = (bot_raw < 0) ? '0 : ((bot_raw > LIM) ? LIM : bot_raw);
    end

    always_comb begin
        box_res.status     = ST_BOX;
        box_res.box_left   = pl[11:0];
        box_res.box_right  = pr[11:0];
        box_res.box_top    = top_c[11:0];
        box_res.box_bottom = bot_c[11:0];
        box_res.word_index = r_wcnt;
        box_res.last       = 1'b0;

        done_res.status     = empty ? ST_ERR : ST_DONE;
        done_res.box_left   = '0;
        done_res.box_right  = '0;
        done_res.box_top    = '0;
        done_res.box_bottom = '0;
        done_res.word_index = empty ? '0 : wcnt_after;
        done_res.last       = 1'b1;

        d0 = box_v ? box_res : done_res;
        d1 = done_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_band  <= 1'b0;
            r_start <= '0;
            r_wcnt  <= '0;
        end else if (fire) begin
            if (r_in.frame_end) begin
                // drop any open band and start the next frame clean
                r_cnt   <= '0;
                r_band  <= 1'b0;
                r_start <= '0;
                r_wcnt  <= '0;
            end else begin
                if (in_area) begin
                    r_cnt <= at_edge ? '0 : cnt_inc;
                end
                r_band  <= band_after && !close_bot;
                r_start <= start_after;
                r_wcnt  <= wcnt_after;
            end
        end
    end

    rpws_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (fire && (box_v || r_in.frame_end)),
        .i_push1 (fire && box_v && r_in.frame_end),
        .i_d0    (d0),
        .i_d1    (d1),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/rpws_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while the reader is ready.
`default_nettype none

module rpws_out_fifo
    import rpws_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push0,
    input  wire logic    i_push1,
    input  wire t_result i_d0,
    input  wire t_result i_d1,
    output logic         o_room2,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    localparam int PTR_W = $clog2(OUT_DEPTH);

    t_result            r_mem [OUT_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic [PTR_W:0]     n_count;
    logic [PTR_W-1:0]   wr_ptr1;
    logic               pop;
    logic [1:0]         push_n;

    assign pop     = (r_count != '0) && i_ready;
    assign push_n  = {1'b0, i_push0} + {1'b0, i_push1};
    assign wr_ptr1 = r_wr_ptr + PTR_W'(1);
    assign n_count = r_count + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
    assign o_room2 = r_count <= (PTR_W+1)'(OUT_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_d0;
        end
        if (i_push1) begin
            r_mem[wr_ptr1] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire
